// ===== rtl/terrain_curvature_class_macros.svh =====
// ============================================================================
// Terrain curvature class assertion macros
// Shared concurrent assertion forms used by the curvature classifier RTL.
// ============================================================================
`ifndef TERRAIN_CURVATURE_CLASS_MACROS_SVH
`define TERRAIN_CURVATURE_CLASS_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define TCC_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define TCC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The condition must hold after the trigger, delayed by the n argument.
`define TCC_ASSERT_DELAY(name, clk, rst_n, ante, n, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcc_pkg.sv =====
// ============================================================================
// Terrain curvature class package
// Widths, class codes and item types shared by the curvature classifier.
// ============================================================================
`default_nettype none

package tcc_pkg;

    // Elevation sample width.
    localparam int ELEV_BITS = 16;

    // Datapath widths, mostly derived from the elevation width or the plane limit width.
    localparam int DZ_W   = ELEV_BITS + 1;          // neighbor minus center
    localparam int DE_W   = ELEV_BITS + 2;          // d, e, g, h
    localparam int F_W    = ELEV_BITS + 3;          // twist sum f
    localparam int SQ_W   = 2 * ELEV_BITS + 3;      // g*g, h*h, g*h
    localparam int PL_W   = 32;                     // plane limit register
    localparam int PLS_W  = PL_W + 1;               // plane limit as signed
    localparam int P_W    = DE_W + SQ_W;            // d*g2 and friends
    localparam int FGH_W  = F_W + SQ_W;             // f*g*h
    localparam int LP_W   = PLS_W + SQ_W;           // limit partial products
    localparam int LIM_W  = LP_W + 1;               // limit * (g2 + h2)
    localparam int N_W    = 3 * ELEV_BITS + 8;      // curvature numerators
    localparam int FRAC_BITS = 16;                  // fraction bits of limit
    localparam int CMP_W  = (N_W + FRAC_BITS > LIM_W) ? N_W + FRAC_BITS : LIM_W;

    // Cycles from an accepted item to its result strobe.
    localparam int LATENCY = 7;

    localparam logic [PL_W-1:0] PLANE_LIMIT_RESET = PL_W'(66);

    // Class codes.
    localparam int CLASS_W = 4;
    localparam logic [CLASS_W-1:0] PLAN_CONCAVE = 4'd0;
    localparam logic [CLASS_W-1:0] PLAN_PLANE   = 4'd3;
    localparam logic [CLASS_W-1:0] PLAN_CONVEX  = 4'd6;
    localparam logic [CLASS_W-1:0] PROF_CONCAVE = 4'd0;
    localparam logic [CLASS_W-1:0] PROF_PLANE   = 4'd1;
    localparam logic [CLASS_W-1:0] PROF_CONVEX  = 4'd2;
    localparam logic [CLASS_W-1:0] CLASS_FLAT   = 4'd4;
    localparam logic [CLASS_W-1:0] CLASS_NODATA = 4'd0;

    typedef struct packed {
        logic                        centre_valid;
        logic [7:0]                  neighbour_valid;
        logic signed [ELEV_BITS-1:0] z_centre;
        logic signed [ELEV_BITS-1:0] z_north;
        logic signed [ELEV_BITS-1:0] z_northeast;
        logic signed [ELEV_BITS-1:0] z_east;
        logic signed [ELEV_BITS-1:0] z_southeast;
        logic signed [ELEV_BITS-1:0] z_south;
        logic signed [ELEV_BITS-1:0] z_southwest;
        logic signed [ELEV_BITS-1:0] z_west;
        logic signed [ELEV_BITS-1:0] z_northwest;
    } item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] cell_class;
        logic               no_data;
    } result_t;

    // Control that travels alongside each item through the pipeline.
    typedef struct packed {
        logic vld;
        logic no_data;
        logic flat;
    } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tcc_diff.sv =====
// ============================================================================
// Curvature classifier difference stages
// Forms the eight neighbor differences, then the surface sums d, e, f, g, h.
// ============================================================================
`default_nettype none

module tcc_diff
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire tcc_pkg::item_t      item,
    output tcc_pkg::ctl_t            ctl_out,
    output logic signed [tcc_pkg::DE_W-1:0] d,
    output logic signed [tcc_pkg::DE_W-1:0] e,
    output logic signed [tcc_pkg::F_W-1:0]  f,
    output logic signed [tcc_pkg::DE_W-1:0] g,
    output logic signed [tcc_pkg::DE_W-1:0] h
);

    localparam int EB  = tcc_pkg::ELEV_BITS;
    localparam int DZW = tcc_pkg::DZ_W;
    localparam int DEW = tcc_pkg::DE_W;
    localparam int FW  = tcc_pkg::F_W;

    logic signed [EB-1:0]  zn [8];
    logic signed [DZW-1:0] dz_next [8];
    logic signed [DZW-1:0] dz_reg  [8];
    tcc_pkg::ctl_t         ctl1_next, ctl1_reg, ctl2_reg;
    logic signed [DEW-1:0] d_next, e_next, g_next, h_next;
    logic signed [DEW-1:0] d_reg, e_reg, g_reg, h_reg;
    logic signed [FW-1:0]  f_next, f_reg;

    // Neighbors in the order N, NE, E, SE, S, SW, W, NW.
    always_comb
    begin
        zn[0] = item.z_north;
        zn[1] = item.z_northeast;
        zn[2] = item.z_east;
        zn[3] = item.z_southeast;
        zn[4] = item.z_south;
        zn[5] = item.z_southwest;
        zn[6] = item.z_west;
        zn[7] = item.z_northwest;
    end

    // A missing neighbor mirrors its opposite through the center, or gives zero when both are missing.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (item.neighbour_valid[i])
            begin
                dz_next[i] = DZW'(zn[i]) - DZW'(item.z_centre);
            end
            else if (item.neighbour_valid[(i + 4) & 7])
            begin
                dz_next[i] = DZW'(item.z_centre) - DZW'(zn[(i + 4) & 7]);
            end
            else
            begin
                dz_next[i] = '0;
            end
        end
        ctl1_next.vld     = accept;
        ctl1_next.no_data = !item.centre_valid;
        ctl1_next.flat    = 1'b0;
    end

    always_comb
    begin
        d_next = DEW'(dz_reg[4]) + DEW'(dz_reg[0]);
        e_next = DEW'(dz_reg[6]) + DEW'(dz_reg[2]);
        f_next = FW'(dz_reg[5]) - FW'(dz_reg[7]) - FW'(dz_reg[3]) + FW'(dz_reg[1]);
        g_next = DEW'(dz_reg[0]) - DEW'(dz_reg[4]);
        h_next = DEW'(dz_reg[2]) - DEW'(dz_reg[6]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dz_reg <= dz_next;
        d_reg  <= d_next;
        e_reg  <= e_next;
        f_reg  <= f_next;
        g_reg  <= g_next;
        h_reg  <= h_next;
    end

    assign ctl_out = ctl2_reg;
    assign d = d_reg;
    assign e = e_reg;
    assign f = f_reg;
    assign g = g_reg;
    assign h = h_reg;

endmodule

`default_nettype wire

// ===== rtl/tcc_terms.sv =====
// ============================================================================
// Curvature classifier product stages
// Squares the gradient, forms the quadratic-surface products and sums them
// into the plan and profile numerators and the scaled plane limit.
// ============================================================================
`default_nettype none

module tcc_terms
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcc_pkg::ctl_t       ctl_in,
    input  wire logic signed [tcc_pkg::DE_W-1:0] d,
    input  wire logic signed [tcc_pkg::DE_W-1:0] e,
    input  wire logic signed [tcc_pkg::F_W-1:0]  f,
    input  wire logic signed [tcc_pkg::DE_W-1:0] g,
    input  wire logic signed [tcc_pkg::DE_W-1:0] h,
    input  wire logic [tcc_pkg::PL_W-1:0]        plane_limit,
    output tcc_pkg::ctl_t            ctl_out,
    output logic signed [tcc_pkg::N_W-1:0]       np,
    output logic signed [tcc_pkg::N_W-1:0]       nl,
    output logic [tcc_pkg::LIM_W-1:0]            lim
);

    localparam int DEW  = tcc_pkg::DE_W;
    localparam int FW   = tcc_pkg::F_W;
    localparam int SQW  = tcc_pkg::SQ_W;
    localparam int PLSW = tcc_pkg::PLS_W;
    localparam int PW   = tcc_pkg::P_W;
    localparam int FGHW = tcc_pkg::FGH_W;
    localparam int LPW  = tcc_pkg::LP_W;
    localparam int LIMW = tcc_pkg::LIM_W;
    localparam int NW   = tcc_pkg::N_W;

    tcc_pkg::ctl_t ctl3_next, ctl3_reg, ctl4_reg, ctl5_reg;

    // Stage 3: squares and cross product of the gradient.
    logic signed [2*DEW-1:0] gg_full, hh_full, gh_full;
    logic signed [SQW-1:0]   g2_reg, h2_reg, gh_reg;
    logic signed [DEW-1:0]   d3_reg, e3_reg;
    logic signed [FW-1:0]    f3_reg;

    // Stage 4: products.
    logic signed [PLSW-1:0]  pl_s;
    logic signed [PW-1:0]    dg2_reg, eh2_reg, eg2_reg, dh2_reg;
    logic signed [FGHW-1:0]  fgh_reg;
    logic signed [LPW-1:0]   lg_reg, lh_reg;

    // Stage 5: sums.
    logic signed [NW-1:0]    np_next, nl_next, np_reg, nl_reg;
    logic [LIMW-1:0]         lim_next, lim_reg;

    assign gg_full = g * g;
    assign hh_full = h * h;
    assign gh_full = g * h;
    assign pl_s    = {1'b0, plane_limit};

    always_comb
    begin
        ctl3_next      = ctl_in;
        ctl3_next.flat = (g == '0) && (h == '0);
    end

    // Four times the curvature terms, with the twist term added or taken off.
    always_comb
    begin
        np_next  = ((NW'(dg2_reg) + NW'(eh2_reg)) <<< 2) + NW'(fgh_reg);
        nl_next  = ((NW'(eg2_reg) + NW'(dh2_reg)) <<< 2) - NW'(fgh_reg);
        lim_next = LIMW'(lg_reg) + LIMW'(lh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else
        begin
            ctl3_reg <= ctl3_next;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g2_reg  <= gg_full[SQW-1:0];
        h2_reg  <= hh_full[SQW-1:0];
        gh_reg  <= gh_full[SQW-1:0];
        d3_reg  <= d;
        e3_reg  <= e;
        f3_reg  <= f;

        dg2_reg <= d3_reg * g2_reg;
        eh2_reg <= e3_reg * h2_reg;
        eg2_reg <= e3_reg * g2_reg;
        dh2_reg <= d3_reg * h2_reg;
        fgh_reg <= f3_reg * gh_reg;
        lg_reg  <= pl_s * g2_reg;
        lh_reg  <= pl_s * h2_reg;

        np_reg  <= np_next;
        nl_reg  <= nl_next;
        lim_reg <= lim_next;
    end

    assign ctl_out = ctl5_reg;
    assign np  = np_reg;
    assign nl  = nl_reg;
    assign lim = lim_reg;

endmodule

`default_nettype wire

// ===== rtl/tcc_judge.sv =====
// ============================================================================
// Curvature classifier decision stages
// Takes numerator magnitudes, tests them against the plane limit and
// registers the final class.
// ============================================================================
`default_nettype none

`include "terrain_curvature_class_macros.svh"

module tcc_judge
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcc_pkg::ctl_t       ctl_in,
    input  wire logic signed [tcc_pkg::N_W-1:0] np,
    input  wire logic signed [tcc_pkg::N_W-1:0] nl,
    input  wire logic [tcc_pkg::LIM_W-1:0]      lim,
    output logic                     done,
    output tcc_pkg::result_t         result
);

    localparam int NW   = tcc_pkg::N_W;
    localparam int LIMW = tcc_pkg::LIM_W;
    localparam int CW   = tcc_pkg::CMP_W;
    localparam int CLW  = tcc_pkg::CLASS_W;

    tcc_pkg::ctl_t     ctl6_reg;
    logic [NW-1:0]     np_mag_next, nl_mag_next, np_mag_reg, nl_mag_reg;
    logic              np_pos_reg, nl_pos_reg;
    logic [LIMW-1:0]   lim6_reg;

    logic [CW-1:0]     np_scaled, nl_scaled, lim_ext;
    logic              np_plane, nl_plane;
    logic [CLW-1:0]    plan, prof;
    tcc_pkg::result_t  result_next, result_reg;
    logic              done_reg;

    always_comb
    begin
        np_mag_next = np[NW-1] ? NW'(-np) : NW'(np);
        nl_mag_next = nl[NW-1] ? NW'(-nl) : NW'(nl);
    end

    // A curvature is plane when its magnitude, scaled to the limit's fixed
    // point, falls below the limit times the squared gradient.
    always_comb
    begin
        np_scaled = CW'(np_mag_reg) << tcc_pkg::FRAC_BITS;
        nl_scaled = CW'(nl_mag_reg) << tcc_pkg::FRAC_BITS;
        lim_ext   = CW'(lim6_reg);
        np_plane  = np_scaled < lim_ext;
        nl_plane  = nl_scaled < lim_ext;

        if (nl_plane)
        begin
            plan = tcc_pkg::PLAN_PLANE;
        end
        else if (nl_pos_reg)
        begin
            plan = tcc_pkg::PLAN_CONCAVE;
        end
        else
        begin
            plan = tcc_pkg::PLAN_CONVEX;
        end

        if (np_plane)
        begin
            prof = tcc_pkg::PROF_PLANE;
        end
        else if (np_pos_reg)
        begin
            prof = tcc_pkg::PROF_CONCAVE;
        end
        else
        begin
            prof = tcc_pkg::PROF_CONVEX;
        end

        result_next.no_data = ctl6_reg.no_data;
        if (ctl6_reg.no_data)
        begin
            result_next.cell_class = tcc_pkg::CLASS_NODATA;
        end
        else if (ctl6_reg.flat)
        begin
            result_next.cell_class = tcc_pkg::CLASS_FLAT;
        end
        else
        begin
            result_next.cell_class = plan + prof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl6_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl6_reg <= ctl_in;
            done_reg <= ctl6_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        np_mag_reg <= np_mag_next;
        nl_mag_reg <= nl_mag_next;
        np_pos_reg <= !np[NW-1] && (np != '0);
        nl_pos_reg <= !nl[NW-1] && (nl != '0);
        lim6_reg   <= lim;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A window with a center and no gradient always comes out plane in both directions.
    `TCC_ASSERT_NEXT(a_flat_class, clk, rst_n, ctl6_reg.vld && ctl6_reg.flat && !ctl6_reg.no_data, done_reg && result_reg.cell_class == tcc_pkg::CLASS_FLAT, "flat window did not give the plane class")

endmodule

`default_nettype wire

// ===== rtl/terrain_curvature_class.sv =====
// ============================================================================
// Terrain curvature class
// Classifies one 3x3 elevation window per cycle into nine plan/profile classes.
// ============================================================================
// Usage: one window item is taken on every clock edge at which start is high;
// busy never rises, so a new item may follow in each cycle. Every item gives
// exactly one result, shown on result for one cycle while done is high. The
// receiver cannot hold results off, and none is needed: the pipeline never
// stalls, so results leave in the same order and at the same rate as items
// enter. In order, two stages build the neighbor differences and surface sums,
// three stages square, multiply and add up the curvature numerators, and two
// stages take magnitudes, compare against the plane limit and register the
// class. The plane limit register loads from the cfg channel, which is always
// ready; it should be written only while no item is in flight, that is, no
// sooner than seven cycles after the last accepted item. cell_class is the
// plan code (concave 0, plane 3, convex 6) plus the profile code (concave 0,
// plane 1, convex 2). A window whose gradient is zero is plane in both
// directions, and an item whose center is missing reports no_data with
// class 0.
// ============================================================================
`default_nettype none

`include "terrain_curvature_class_macros.svh"

module terrain_curvature_class
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire tcc_pkg::item_t             window,
    output logic                            done,
    output tcc_pkg::result_t                result,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [tcc_pkg::PL_W-1:0]   cfg_data
);

    localparam int PLW = tcc_pkg::PL_W;

    logic                    accept;
    logic [PLW-1:0]          plane_limit_reg, plane_limit_next;

    tcc_pkg::ctl_t           diff_ctl, terms_ctl;
    logic signed [tcc_pkg::DE_W-1:0] sum_d, sum_e, sum_g, sum_h;
    logic signed [tcc_pkg::F_W-1:0]  sum_f;
    logic signed [tcc_pkg::N_W-1:0]  num_prof, num_plan;
    logic [tcc_pkg::LIM_W-1:0]       scaled_lim;

    // The pipeline always advances, so an item is taken whenever one is offered.
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // The plane limit holds its value until the cfg channel writes it.
    always_comb
    begin
        plane_limit_next = plane_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            plane_limit_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_limit_reg <= tcc_pkg::PLANE_LIMIT_RESET;
        end
        else
        begin
            plane_limit_reg <= plane_limit_next;
        end
    end

    // Neighbor differences and the sums d, e, f, g, h.
    tcc_diff u_diff
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (window),
        .ctl_out (diff_ctl),
        .d       (sum_d),
        .e       (sum_e),
        .f       (sum_f),
        .g       (sum_g),
        .h       (sum_h)
    );

    // Quadratic-surface products, numerators and the limit scaled by g^2 + h^2.
    tcc_terms u_terms
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_in      (diff_ctl),
        .d           (sum_d),
        .e           (sum_e),
        .f           (sum_f),
        .g           (sum_g),
        .h           (sum_h),
        .plane_limit (plane_limit_reg),
        .ctl_out     (terms_ctl),
        .np          (num_prof),
        .nl          (num_plan),
        .lim         (scaled_lim)
    );

    // Threshold tests and the final class register.
    tcc_judge u_judge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (terms_ctl),
        .np     (num_prof),
        .nl     (num_plan),
        .lim    (scaled_lim),
        .done   (done),
        .result (result)
    );

    // Every item with a missing center comes back as no data after the pipeline depth.
    `TCC_ASSERT_DELAY(a_nodata_result, clk, rst_n, accept && !window.centre_valid, tcc_pkg::LATENCY, done && result.no_data && result.cell_class == tcc_pkg::CLASS_NODATA, "missing center did not give a no data result")

    // Every item with a valid center comes back as a classified result.
    `TCC_ASSERT_DELAY(a_valid_result, clk, rst_n, accept && window.centre_valid, tcc_pkg::LATENCY, done && !result.no_data, "valid window did not give a classified result")

endmodule

`default_nettype wire
